// ===== rtl/bilateral_filter_5x5_macros.svh =====
// Assertion shorthands used by the filter RTL.
`ifndef BILATERAL_FILTER_5X5_MACROS_SVH
`define BILATERAL_FILTER_5X5_MACROS_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define BF5_ASSERT_NOW(name, cond, prop) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error("bf5 assertion failed");

// Next-cycle implication, sampled on aclk, off during reset.
`define BF5_ASSERT_NEXT(name, cond, prop) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error("bf5 assertion failed");

`endif

// ===== rtl/bf5_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bf5_pkg;

    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int MAX_RADIUS_DEF  = 2;
    localparam int WEIGHT_BITS_DEF = 8;

    localparam int MAX_HEIGHT   = 4095;
    localparam int MIN_SIDE     = 5;
    localparam int EXP_ENTRIES  = 256;
    localparam int INDEX_SHIFT  = 12;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 16;
    localparam logic [63:0] EXP_STEP = 64'd4034748382;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_RADIUS = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_SCALE   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPATIAL_SCALE = 3'd4;

    typedef logic [15:0] rom_t [EXP_ENTRIES];

    // exp(-k/16) in Q32.32 by repeated multiply, rounded to wb bits, saturated
    function automatic rom_t build_rom(input int wb);
        rom_t        rom;
        logic [63:0] e;
        logic [63:0] w;
        logic [63:0] top;
        e   = 64'd1 << 32;
        top = (64'd1 << wb) - 64'd1;
        for (int k = 0; k < EXP_ENTRIES; k++) begin
            w      = (e + (64'd1 << (31 - wb))) >> (32 - wb);
            rom[k] = (w > top) ? top[15:0] : w[15:0];
            e      = (e * EXP_STEP + (64'd1 << 31)) >> 32;
        end
        return rom;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bilateral_filter_5x5.sv =====
// Channel | Direction | Ports                                  | Transfer when
// --------+-----------+----------------------------------------+--------------------
// s_      | in        | s_pixel_in, s_is_padding               | s_valid & s_ready
// m_      | out       | m_pixel_out, m_frame_last              | m_valid & m_ready
// cfg_    | in        | cfg_index, cfg_data                    | cfg_valid & cfg_ready
//
// Steps: an item with no result only passes ST_IDLE. An edge pixel result goes
//   through ST_CTR, ST_CTRD and ST_HOLD; an interior one also steps through the
//   (2R+1)^2 taps, one single-port line-store read each, then the 8-step divider.
// Reset: aresetn synchronous, active low; line store contents are not cleared.
// Stalls: s_ready drops while a result is computed or waits in ST_HOLD; the output
//   register holds one finished result, so the next item is taken while it waits.
`timescale 1ns / 1ps
`default_nettype none
`include "bilateral_filter_5x5_macros.svh"

module bilateral_filter_5x5 #(
    parameter int MAX_WIDTH   = bf5_pkg::MAX_WIDTH_DEF,
    parameter int MAX_RADIUS  = bf5_pkg::MAX_RADIUS_DEF,
    parameter int WEIGHT_BITS = bf5_pkg::WEIGHT_BITS_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire [bf5_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire [bf5_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire [7:0]                        s_pixel_in,
    input  wire                              s_is_padding,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic [7:0]                       m_pixel_out,
    output logic                             m_frame_last
);
    import bf5_pkg::*;

    // history ring: 2R lines plus 2R+1 pixels
    localparam int D    = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
    localparam int AW   = $clog2(D);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int HW   = 12;
    localparam int RW   = $clog2(MAX_RADIUS + 1);
    localparam int SW   = $clog2(2 * MAX_RADIUS + 1);
    localparam int NW   = $clog2(MAX_WIDTH * (MAX_HEIGHT + MAX_RADIUS + 1) + MAX_RADIUS + 1);
    localparam int DSW  = $clog2(2 * MAX_RADIUS * MAX_RADIUS + 1);
    localparam int TAPS = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int DENW = 2 * WEIGHT_BITS + $clog2(TAPS + 1);
    localparam int NUMW = DENW + 8;
    localparam rom_t EXP_ROM = build_rom(WEIGHT_BITS);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_CTR  = 6'b000010,
        ST_CTRD = 6'b000100,
        ST_TAP  = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_HOLD = 6'b100000
    } state_t;

    // per-tap steps
    localparam logic [2:0] PH_READ = 3'd0;
    localparam logic [2:0] PH_DATA = 3'd1;
    localparam logic [2:0] PH_PROD = 3'd2;
    localparam logic [2:0] PH_LOOK = 3'd3;
    localparam logic [2:0] PH_WGT  = 3'd4;
    localparam logic [2:0] PH_ACC  = 3'd5;

    state_t                  state_reg;
    logic [2:0]              phase_reg;
    logic [10:0]             width_cfg_reg;
    logic [11:0]             height_cfg_reg;
    logic [1:0]              radius_cfg_reg;
    logic [15:0]             range_scale_reg;
    logic [15:0]             spatial_scale_reg;
    logic [NW-1:0]           n_reg;
    logic [WW-1:0]           tx_reg;
    logic [HW-1:0]           ty_reg;
    logic [AW-1:0]           wp_reg;
    logic [AW-1:0]           cur_reg;
    logic [AW-1:0]           tap_addr_reg;
    logic                    interior_reg;
    logic                    last_reg;
    logic [7:0]              rd_q_reg;
    logic [7:0]              centre_reg;
    logic [7:0]              v_reg;
    logic [15:0]             dd_reg;
    logic [DSW-1:0]          sd_reg;
    logic [31:0]             rprod_reg;
    logic [31:0]             sprod_reg;
    logic [WEIGHT_BITS-1:0]  wr_reg;
    logic [WEIGHT_BITS-1:0]  ws_reg;
    logic [2*WEIGHT_BITS-1:0] wt_reg;
    logic [NUMW-1:0]         num_reg;
    logic [DENW-1:0]         den_reg;
    logic [NUMW-1:0]         rem_reg;
    logic [7:0]              q_reg;
    logic [2:0]              k_reg;
    logic [SW-1:0]           i_reg;
    logic [SW-1:0]           j_reg;
    logic [7:0]              result_reg;
    logic                    m_valid_reg;
    logic [7:0]              m_pixel_reg;
    logic                    m_last_reg;

    logic [7:0]              mem [D];

    // ---------------- effective geometry ----------------
    logic [12:0]      w_raw;
    logic [WW-1:0]    w_eff;
    logic [HW-1:0]    h_eff;
    logic [RW-1:0]    r_eff;
    logic [NW-1:0]    total;
    logic [NW-1:0]    delay;

    always_comb begin
        w_raw = {2'b00, width_cfg_reg};
        if (w_raw < 13'(MIN_SIDE)) begin
            w_eff = WW'(MIN_SIDE);
        end else if (w_raw > 13'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(w_raw);
        end
        h_eff = (height_cfg_reg < 12'(MIN_SIDE)) ? 12'(MIN_SIDE) : height_cfg_reg;
        r_eff = ({1'b0, radius_cfg_reg} > 3'(MAX_RADIUS)) ? RW'(MAX_RADIUS)
                                                           : RW'(radius_cfg_reg);
        total = NW'(w_eff) * NW'(h_eff);
        delay = NW'(r_eff) * NW'(w_eff) + NW'(r_eff);
    end

    function automatic logic [AW-1:0] ring_sub(input logic [AW-1:0] a,
                                               input logic [AW-1:0] b);
        logic [AW:0] s;
        s = (a >= b) ? {1'b0, a} - {1'b0, b} : {1'b0, a} + (AW+1)'(D) - {1'b0, b};
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a,
                                               input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (AW+1)'(D)) begin
            s = s - (AW+1)'(D);
        end
        return s[AW-1:0];
    endfunction

    // ---------------- accept decision ----------------
    logic          draining;
    logic          live;
    logic          restart;
    logic          due;
    logic          accept;
    logic [NW-1:0] t_pos;
    logic          interior;
    logic [AW-1:0] wp_inc;

    always_comb begin
        draining = (n_reg >= total);
        live     = draining || !s_is_padding;
        accept   = s_valid && s_ready && live;
        restart  = (n_reg >= total + delay - NW'(1));
        due      = (n_reg >= delay);
        t_pos    = n_reg - delay;
        interior = (r_eff != '0)
                && (ty_reg >= HW'(r_eff))
                && ((HW+1)'(ty_reg) + (HW+1)'(r_eff) < (HW+1)'(h_eff))
                && (tx_reg >= WW'(r_eff))
                && ((WW+1)'(tx_reg) + (WW+1)'(r_eff) < (WW+1)'(w_eff));
        wp_inc   = ring_add(wp_reg, AW'(1));
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // ---------------- line store ----------------
    logic [AW-1:0] rd_addr;
    assign rd_addr = (state_reg == ST_CTR) ? ring_sub(cur_reg, AW'(delay)) : tap_addr_reg;

    always_ff @(posedge aclk) begin
        if (accept) begin
            mem[wp_reg] <= draining ? 8'd0 : s_pixel_in;
        end
        rd_q_reg <= mem[rd_addr];
    end

    // ---------------- tap arithmetic ----------------
    logic [SW-1:0]          side_m1;
    logic [SW-1:0]          di;
    logic [SW-1:0]          dj;
    logic [7:0]             ad;
    logic [7:0]             ridx;
    logic [7:0]             sidx;
    logic [NUMW-1:0]        num_sum;
    logic [DENW-1:0]        den_sum;
    logic                   last_tap;
    logic [NUMW-1:0]        div_sub;
    logic                   div_fit;

    always_comb begin
        side_m1  = SW'(r_eff) << 1;
        di       = (i_reg >= SW'(r_eff)) ? i_reg - SW'(r_eff) : SW'(r_eff) - i_reg;
        dj       = (j_reg >= SW'(r_eff)) ? j_reg - SW'(r_eff) : SW'(r_eff) - j_reg;
        ad       = (rd_q_reg >= centre_reg) ? rd_q_reg - centre_reg : centre_reg - rd_q_reg;
        ridx     = (rprod_reg[31:INDEX_SHIFT+8] != '0) ? 8'hFF
                                                       : rprod_reg[INDEX_SHIFT+7:INDEX_SHIFT];
        sidx     = (sprod_reg[31:INDEX_SHIFT+8] != '0) ? 8'hFF
                                                       : sprod_reg[INDEX_SHIFT+7:INDEX_SHIFT];
        num_sum  = num_reg + NUMW'(wt_reg * v_reg);
        den_sum  = den_reg + DENW'(wt_reg);
        last_tap = (i_reg == side_m1) && (j_reg == side_m1);
        div_sub  = NUMW'(den_reg) << k_reg;
        div_fit  = (rem_reg >= div_sub);
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            phase_reg         <= PH_READ;
            width_cfg_reg     <= 11'd1024;
            height_cfg_reg    <= 12'd480;
            radius_cfg_reg    <= 2'd2;
            range_scale_reg   <= 16'd2330;
            spatial_scale_reg <= 16'd2048;
            n_reg             <= '0;
            tx_reg            <= '0;
            ty_reg            <= '0;
            wp_reg            <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        wp_reg  <= wp_inc;
                        cur_reg <= wp_reg;
                        n_reg   <= restart ? '0 : n_reg + NW'(1);
                        if (due) begin
                            interior_reg <= interior;
                            last_reg     <= (t_pos == total - NW'(1));
                            state_reg    <= ST_CTR;
                            // next result position
                            if (tx_reg + WW'(1) >= w_eff) begin
                                tx_reg <= '0;
                                ty_reg <= ty_reg + HW'(1);
                            end else begin
                                tx_reg <= tx_reg + WW'(1);
                            end
                        end
                        if (restart) begin
                            tx_reg <= '0;
                            ty_reg <= '0;
                        end
                    end
                end
                ST_CTR: begin
                    state_reg <= ST_CTRD;
                end
                ST_CTRD: begin
                    centre_reg <= rd_q_reg;
                    if (interior_reg) begin
                        state_reg    <= ST_TAP;
                        phase_reg    <= PH_READ;
                        i_reg        <= '0;
                        j_reg        <= '0;
                        num_reg      <= '0;
                        den_reg      <= '0;
                        tap_addr_reg <= ring_sub(cur_reg, AW'(delay << 1));
                    end else begin
                        result_reg <= rd_q_reg;
                        state_reg  <= ST_HOLD;
                    end
                end
                ST_TAP: begin
                    case (phase_reg)
                        PH_READ: begin
                            phase_reg <= PH_DATA;
                        end
                        PH_DATA: begin
                            v_reg     <= rd_q_reg;
                            dd_reg    <= ad * ad;
                            sd_reg    <= DSW'(di * di) + DSW'(dj * dj);
                            phase_reg <= PH_PROD;
                        end
                        PH_PROD: begin
                            rprod_reg <= dd_reg * range_scale_reg;
                            sprod_reg <= 32'(sd_reg) * 32'(spatial_scale_reg);
                            phase_reg <= PH_LOOK;
                        end
                        PH_LOOK: begin
                            wr_reg    <= EXP_ROM[ridx][WEIGHT_BITS-1:0];
                            ws_reg    <= EXP_ROM[sidx][WEIGHT_BITS-1:0];
                            phase_reg <= PH_WGT;
                        end
                        PH_WGT: begin
                            wt_reg    <= wr_reg * ws_reg;
                            phase_reg <= PH_ACC;
                        end
                        PH_ACC: begin
                            num_reg   <= num_sum;
                            den_reg   <= den_sum;
                            phase_reg <= PH_READ;
                            if (last_tap) begin
                                rem_reg   <= num_sum;
                                q_reg     <= '0;
                                k_reg     <= 3'd7;
                                state_reg <= ST_DIV;
                            end else if (j_reg == side_m1) begin
                                j_reg        <= '0;
                                i_reg        <= i_reg + SW'(1);
                                // next row starts one line on, 2R columns back
                                tap_addr_reg <= ring_sub(ring_add(tap_addr_reg, AW'(w_eff)),
                                                         AW'(side_m1));
                            end else begin
                                j_reg        <= j_reg + SW'(1);
                                tap_addr_reg <= ring_add(tap_addr_reg, AW'(1));
                            end
                        end
                        default: begin
                            phase_reg <= PH_READ;
                        end
                    endcase
                end
                ST_DIV: begin
                    // restoring divide, one quotient bit per cycle
                    if (div_fit) begin
                        rem_reg        <= rem_reg - div_sub;
                        q_reg[k_reg]   <= 1'b1;
                    end
                    if (k_reg == 3'd0) begin
                        result_reg <= {q_reg[7:1], div_fit};
                        state_reg  <= ST_HOLD;
                    end else begin
                        k_reg <= k_reg - 3'd1;
                    end
                end
                ST_HOLD: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_pixel_reg <= result_reg;
                        m_last_reg  <= last_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // geometry writes restart the frame
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH: begin
                        width_cfg_reg <= cfg_data[10:0];
                        n_reg <= '0; tx_reg <= '0; ty_reg <= '0;
                    end
                    CFG_IMAGE_HEIGHT: begin
                        height_cfg_reg <= cfg_data[11:0];
                        n_reg <= '0; tx_reg <= '0; ty_reg <= '0;
                    end
                    CFG_WINDOW_RADIUS: begin
                        radius_cfg_reg <= cfg_data[1:0];
                        n_reg <= '0; tx_reg <= '0; ty_reg <= '0;
                    end
                    CFG_RANGE_SCALE:   range_scale_reg   <= cfg_data;
                    CFG_SPATIAL_SCALE: spatial_scale_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_pixel_out  = m_pixel_reg;
    assign m_frame_last = m_last_reg;

    // centre tap weight is never zero, so the divisor is nonzero
    `BF5_ASSERT_NOW(a_den_nonzero, state_reg == ST_DIV, den_reg != '0)
    `BF5_ASSERT_NEXT(a_due_starts, accept && due, state_reg == ST_CTR)
    `BF5_ASSERT_NEXT(a_hold_loads, (state_reg == ST_HOLD) && (!m_valid_reg || m_ready),
                     m_valid_reg)

endmodule

`default_nettype wire

// ===== tb/bilateral_filter_5x5_tb.sv =====
`timescale 1ns / 1ps

module bilateral_filter_5x5_tb;
    import bf5_pkg::*;

    // predictor sizes, fixed to the default build of the block
    localparam int WIDTH_CAP   = 1024;
    localparam int RADIUS_CAP  = 2;
    localparam int WBITS       = 8;
    localparam int STORE_DEPTH = 2 * RADIUS_CAP * WIDTH_CAP + 2 * RADIUS_CAP + 1;
    // indexes past the last register, ignored by the block
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 3'd5;

    typedef struct packed {
        logic [7:0] pixel;
        logic       padding;
    } pixel_item_t;

    typedef struct packed {
        logic [7:0] pixel;
        logic       last;
    } filtered_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_pixel_in = '0;
    logic       s_is_padding = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_pixel_out;
    logic       m_frame_last;

    bilateral_filter_5x5 i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel_in   (s_pixel_in),
        .s_is_padding (s_is_padding),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_out  (m_pixel_out),
        .m_frame_last (m_frame_last)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // pending source items and expected filtered pixels
    pixel_item_t pixel_queue[$];
    filtered_t   filtered_queue[$];
    int          error_count = 0;
    int          accepted_count = 0;
    int          queued_count = 0;
    bit          in_taken = 0;
    bit          sink_hold = 0;

    // ---------------- filter model state ----------------
    int unsigned exp_weight [EXP_ENTRIES];
    int unsigned img_w = 1024, img_h = 480, win_r = 2;
    int unsigned rng_scale = 2330, spa_scale = 2048;
    logic [7:0]  history [STORE_DEPTH];
    int unsigned col_cnt = 0, row_cnt = 0, drain_cnt = 0, wr_ptr = 0;
    bit          draining = 0;

    initial begin
        longint unsigned e;
        longint unsigned w;
        e = 64'd1 << 32;
        for (int k = 0; k < EXP_ENTRIES; k++) begin
            w = (e + (64'd1 << (31 - WBITS))) >> (32 - WBITS);
            exp_weight[k] = 32'((w > (1 << WBITS) - 1) ? (1 << WBITS) - 1 : w);
            e = (e * EXP_STEP + (64'd1 << 31)) >> 32;
        end
        for (int k = 0; k < STORE_DEPTH; k++) history[k] = '0;
    end

    function automatic int unsigned exp_lookup(longint unsigned arg, int unsigned scale);
        longint unsigned idx;
        idx = (arg * scale) >> INDEX_SHIFT;
        if (idx > EXP_ENTRIES - 1) idx = EXP_ENTRIES - 1;
        return exp_weight[idx];
    endfunction

    function automatic logic [7:0] history_tap(int unsigned cur, int unsigned back);
        return history[(cur + STORE_DEPTH - back) % STORE_DEPTH];
    endfunction

    function automatic void restart_frame();
        col_cnt   = 0;
        row_cnt   = 0;
        draining  = 0;
        drain_cnt = 0;
    endfunction

    function automatic void apply_register(logic [CFG_INDEX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_IMAGE_WIDTH: begin
                img_w = data[10:0];
                restart_frame();
            end
            CFG_IMAGE_HEIGHT: begin
                img_h = data[11:0];
                restart_frame();
            end
            CFG_WINDOW_RADIUS: begin
                win_r = data[1:0];
                restart_frame();
            end
            CFG_RANGE_SCALE: rng_scale = data;
            CFG_SPATIAL_SCALE: spa_scale = data;
            default: ;
        endcase
    endfunction

    // one source transfer in, at most one filtered pixel expected out
    function automatic void filter_pixel(logic [7:0] pix, logic pad);
        int unsigned w, h, r, total, delay, n, cur, t, ty, tx, side, back;
        longint unsigned num, den, wt, q;
        int d, dy, dx;
        logic [7:0] centre, v;
        filtered_t res;
        w = (img_w < MIN_SIDE) ? MIN_SIDE : (img_w > WIDTH_CAP) ? WIDTH_CAP : img_w;
        h = (img_h < MIN_SIDE) ? MIN_SIDE : (img_h > MAX_HEIGHT) ? MAX_HEIGHT : img_h;
        r = (win_r > RADIUS_CAP) ? RADIUS_CAP : win_r;
        total = w * h;
        delay = r * w + r;
        cur = wr_ptr;
        if (!draining) begin
            if (pad) return;     // bubble inside the frame
            history[cur] = pix;
            n = row_cnt * w + col_cnt;
            col_cnt++;
            if (col_cnt >= w) begin
                col_cnt = 0;
                row_cnt++;
            end
            if (n >= total - 1) begin
                draining  = 1;
                drain_cnt = 0;
            end
        end else begin
            history[cur] = '0;
            n = total + drain_cnt;
            drain_cnt++;
        end
        wr_ptr = (cur + 1) % STORE_DEPTH;
        if (n >= total + delay - 1) restart_frame();
        if (n < delay) return;
        t  = n - delay;
        ty = t / w;
        tx = t % w;
        centre = history_tap(cur, delay);
        res.pixel = centre;
        if (r > 0 && ty >= r && ty + r < h && tx >= r && tx + r < w) begin
            num  = 0;
            den  = 0;
            side = 2 * r + 1;
            for (int i = 0; i < side; i++) begin
                for (int j = 0; j < side; j++) begin
                    back = (2 * r - i) * w + (2 * r - j);
                    v  = history_tap(cur, back);
                    d  = int'(v) - int'(centre);
                    dy = i - int'(r);
                    dx = j - int'(r);
                    wt = longint'(exp_lookup(d * d, rng_scale)) *
                         exp_lookup(dy * dy + dx * dx, spa_scale);
                    num += wt * v;
                    den += wt;
                end
            end
            if (den != 0) begin
                q = num / den;
                res.pixel = (q > 255) ? 8'd255 : q[7:0];
            end
        end
        res.last = (t == total - 1);
        filtered_queue.push_back(res);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // ---------------- sampling at the rising edge ----------------
    always @(posedge aclk) begin
        filtered_t want;
        in_taken = 0;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) apply_register(cfg_index, cfg_data);
            if (s_valid && s_ready) begin
                in_taken = 1;
                accepted_count++;
                filter_pixel(s_pixel_in, s_is_padding);
            end
            if (m_valid && m_ready) begin
                if (filtered_queue.size() == 0) begin
                    report_mismatch("unexpected transfer, pixel", m_pixel_out, -1);
                end else begin
                    want = filtered_queue.pop_front();
                    if (m_pixel_out !== want.pixel)
                        report_mismatch("pixel_out", m_pixel_out, want.pixel);
                    if (m_frame_last !== want.last)
                        report_mismatch("frame_last", m_frame_last, want.last);
                end
            end
        end
    end

    // no idling on either side in this window of transfers
    function automatic bit calm_stretch();
        return accepted_count >= 700 && accepted_count < 900;
    endfunction

    // ---------------- source driver ----------------
    always @(negedge aclk) begin
        pixel_item_t item;
        if (aresetn && (!s_valid || in_taken)) begin
            if (pixel_queue.size() != 0 &&
                (calm_stretch() || $urandom_range(99) >= 26)) begin
                item = pixel_queue.pop_front();
                s_valid      <= 1'b1;
                s_pixel_in   <= item.pixel;
                s_is_padding <= item.padding;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ---------------- result sink ----------------
    always @(negedge aclk) begin
        m_ready <= !sink_hold && (calm_stretch() || $urandom_range(99) >= 26);
    end

    // long receiver hold-off so the output stage fills and s_ready drops
    initial begin
        while (accepted_count < 300) @(posedge aclk);
        sink_hold = 1;
        repeat (4000) @(posedge aclk);
        sink_hold = 0;
    end

    // ---------------- stimulus ----------------
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pixel_queue.size() != 0 || s_valid || filtered_queue.size() != 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_pixel(int mode, logic [7:0] base);
        case (mode)
            0: return 8'($urandom_range(255));
            1: return 8'(base + $urandom_range(12) - 6);
            default: return $urandom_range(1) ? 8'd255 : 8'd0;
        endcase
    endfunction

    // program the geometry and scales, then queue a frame (or part of one)
    task automatic run_phase(int unsigned w, int unsigned h, int unsigned r,
                             int unsigned rs, int unsigned ss, int part);
        int unsigned ew, eh, er, total, delay, count, mode;
        logic [7:0] base;
        pixel_item_t item;
        wait_idle();
        // junk above each register's width is dropped by the block
        write_reg(CFG_IMAGE_WIDTH, {5'($urandom_range(31)), w[10:0]});
        write_reg(CFG_IMAGE_HEIGHT, {4'($urandom_range(15)), h[11:0]});
        write_reg(CFG_WINDOW_RADIUS, {14'($urandom_range(16383)), r[1:0]});
        write_reg(CFG_RANGE_SCALE, rs[15:0]);
        write_reg(CFG_SPATIAL_SCALE, ss[15:0]);
        if ($urandom_range(3) == 0)
            write_reg(CFG_INDEX_W'(CFG_SPARE + $urandom_range(2)),
                      CFG_DATA_W'($urandom_range(65535)));
        ew = (w < MIN_SIDE) ? MIN_SIDE : (w > WIDTH_CAP) ? WIDTH_CAP : w;
        eh = (h < MIN_SIDE) ? MIN_SIDE : (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
        er = (r > RADIUS_CAP) ? RADIUS_CAP : r;
        total = ew * eh;
        delay = er * ew + er;
        count = (part > 0) ? part : total;
        mode = $urandom_range(2);
        base = 8'($urandom_range(255));
        for (int k = 0; k < count; k++) begin
            // bubbles inside the frame
            while ($urandom_range(19) == 0) begin
                item.pixel   = 8'($urandom_range(255));
                item.padding = 1'b1;
                pixel_queue.push_back(item);
                queued_count++;
            end
            item.pixel   = pick_pixel(mode, base);
            item.padding = 1'b0;
            pixel_queue.push_back(item);
            queued_count++;
        end
        if (part == 0) begin
            // drain items; is_padding does not matter once the frame is in
            for (int k = 0; k < delay; k++) begin
                item.pixel   = 8'($urandom_range(255));
                item.padding = $urandom_range(3) != 0;
                pixel_queue.push_back(item);
                queued_count++;
            end
        end
    endtask

    initial begin
        int unsigned rs, ss;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // directed: flat weights, steepest weights, small radius, clamps
        run_phase(5, 5, 2, 0, 0, 0);
        run_phase(5, 5, 2, 65535, 65535, 0);
        run_phase(6, 7, 1, 2330, 2048, 0);
        run_phase(2047, 5, 0, 100, 100, 24);
        run_phase(0, 0, 3, 2330, 2048, 0);
        run_phase(5, 4095, 1, 500, 4096, 20);
        run_phase(1024, 5, 0, 65535, 0, 40);

        while (queued_count < 1400) begin
            rs = $urandom_range(3) == 0 ? ($urandom_range(1) ? 65535 : 0)
                                        : $urandom_range(8000);
            ss = $urandom_range(3) == 0 ? ($urandom_range(1) ? 65535 : 0)
                                        : $urandom_range(8000);
            run_phase($urandom_range(7) == 0 ? $urandom_range(4) : $urandom_range(9, 5),
                      $urandom_range(7) == 0 ? $urandom_range(4) : $urandom_range(8, 5),
                      $urandom_range(3), rs, ss,
                      $urandom_range(9) == 0 ? $urandom_range(30, 1) : 0);
        end

        wait_idle();
        repeat (200) @(posedge aclk);
        if (error_count == 0) begin
            $display("PASS bilateral_filter_5x5");
        end else begin
            $display("FAIL bilateral_filter_5x5");
        end
        $finish;
    end

    // run limit
    initial begin
        #8000000;
        $display("FAIL bilateral_filter_5x5");
        $finish;
    end

endmodule

// ===== bilateral_filter_5x5.f =====
+incdir+rtl
rtl/bf5_pkg.sv
rtl/bilateral_filter_5x5.sv
tb/bilateral_filter_5x5_tb.sv
